>>> rtl/can_signal_extractor_core_assert.svh
// assertion macros shared by the checker
`ifndef CAN_SIGNAL_EXTRACTOR_CORE_ASSERT_SVH
`define CAN_SIGNAL_EXTRACTOR_CORE_ASSERT_SVH

// property checked outside reset
`define CSE_ASSERT_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define CSE_ASSERT_ALL(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/cse_pkg.sv
`timescale 1ns / 1ps
package cse_pkg;

    localparam int SIGNAL_SLOTS = 8;
    localparam int REG_SLOTS    = 8;
    localparam int CFG_IDX_W    = $clog2(REG_SLOTS);
    localparam int ENTRY_W      = 30;
    localparam int FRAME_ID_W   = 29;
    localparam int ID_W         = 16;
    localparam int DATA_W       = 64;
    localparam int START_W      = 6;
    localparam int SIZE_W       = 7;
    localparam int SLOT_W       = 3;

    localparam int START_LSB    = 16;
    localparam int SIZE_LSB     = 22;
    localparam int ENABLE_BIT   = 29;

    typedef struct packed {
        logic                valid;
        logic [SLOT_W-1:0]   slot;
        logic                last;
        logic [START_W-1:0]  start;
        logic [SIZE_W-1:0]   size;
        logic [DATA_W-1:0]   data;
    } t_issue;

    typedef struct packed {
        logic                valid;
        logic [SLOT_W-1:0]   slot;
        logic                last;
        logic [DATA_W-1:0]   value;
    } t_result;

endpackage

>>> rtl/can_signal_extractor_core.sv
`timescale 1ns / 1ps
// a frame passes capture, match, serialiser and extract stages a and b; its results follow back to back
// throughput: one frame per cycle while frames match at most one slot; a frame with more matches
//   holds the slot serialiser until its last slot is issued, and busy rises once the match stage backs up
// frames that match no slot leave the pipe at the match stage and emit nothing
// reset: synchronous, active low; clears the descriptors and every stage valid bit
// the receiver cannot stall: each result is shown for exactly one cycle
module can_signal_extractor_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [cse_pkg::FRAME_ID_W-1:0]  i_frame_id,
    input  logic [cse_pkg::DATA_W-1:0]      i_frame_data,
    input  logic                            i_cfg_we,
    input  logic [cse_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cse_pkg::ENTRY_W-1:0]     i_cfg_data,
    output logic                            o_strobe,
    output logic [cse_pkg::SLOT_W-1:0]      o_slot_index,
    output logic [cse_pkg::DATA_W-1:0]      o_signal_value,
    output logic                            o_last_of_frame
);

    logic [cse_pkg::ENTRY_W-1:0]       r_entry [cse_pkg::REG_SLOTS];

    logic                              r1_valid;
    logic [cse_pkg::ID_W-1:0]          r1_id;
    logic [cse_pkg::DATA_W-1:0]        r1_data;

    logic                              r2_valid;
    logic [cse_pkg::SIGNAL_SLOTS-1:0]  r2_mask;
    logic [cse_pkg::DATA_W-1:0]        r2_data;

    logic                              r3_valid;
    logic [cse_pkg::SIGNAL_SLOTS-1:0]  r3_mask;
    logic [cse_pkg::DATA_W-1:0]        r3_data;

    logic                              accept;
    logic                              r1_ready;
    logic                              r2_ready;
    logic                              r3_ready;
    logic [cse_pkg::SIGNAL_SLOTS-1:0]  n_mask;
    logic [cse_pkg::SIGNAL_SLOTS-1:0]  low_bit;
    logic [cse_pkg::SIGNAL_SLOTS-1:0]  rest_mask;
    logic [cse_pkg::SLOT_W-1:0]        sel;
    logic [cse_pkg::ENTRY_W-1:0]       sel_entry;

    cse_pkg::t_issue                   issue;
    cse_pkg::t_result                  result;

    // descriptor registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < cse_pkg::REG_SLOTS; k++) begin
                r_entry[k] <= '0;
            end
        end else if (i_cfg_we) begin
            r_entry[i_cfg_index] <= i_cfg_data;
        end
    end

    // stage flow
    assign r3_ready = !r3_valid || (rest_mask == '0);
    assign r2_ready = !r2_valid || r3_ready;
    assign r1_ready = !r1_valid || r2_ready;
    assign o_busy   = !r1_ready;
    assign accept   = i_start && r1_ready;

    // frame capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (r1_ready) begin
            r1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_id   <= i_frame_id[cse_pkg::ID_W-1:0];
            r1_data <= i_frame_data;
        end
    end

    // id compare against every slot
    always_comb begin
        for (int k = 0; k < cse_pkg::SIGNAL_SLOTS; k++) begin
            n_mask[k] = r_entry[k][cse_pkg::ENABLE_BIT] &&
                        (r_entry[k][cse_pkg::ID_W-1:0] == r1_id);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (r2_ready) begin
            r2_valid <= r1_valid && (n_mask != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r2_ready) begin
            r2_mask <= n_mask;
            r2_data <= r1_data;
        end
    end

    // slot serialiser, lowest slot first
    always_comb begin
        sel = '0;
        for (int k = cse_pkg::SIGNAL_SLOTS - 1; k >= 0; k--) begin
            if (r3_mask[k]) begin
                sel = cse_pkg::SLOT_W'(k);
            end
        end
        low_bit   = r3_mask & ((~r3_mask) + cse_pkg::SIGNAL_SLOTS'(1));
        rest_mask = r3_mask & ~low_bit;
        sel_entry = r_entry[sel];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (r3_ready) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r3_ready) begin
            r3_mask <= r2_mask;
            r3_data <= r2_data;
        end else begin
            r3_mask <= rest_mask;
        end
    end

    always_comb begin
        issue.valid = r3_valid;
        issue.slot  = sel;
        issue.last  = (rest_mask == '0);
        issue.start = sel_entry[cse_pkg::START_LSB +: cse_pkg::START_W];
        issue.size  = sel_entry[cse_pkg::SIZE_LSB +: cse_pkg::SIZE_W];
        issue.data  = r3_data;
    end

    cse_extract u_extract (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_issue  (issue),
        .o_result (result)
    );

    assign o_strobe        = result.valid;
    assign o_slot_index    = result.slot;
    assign o_signal_value  = result.value;
    assign o_last_of_frame = result.valid && result.last;

endmodule

>>> rtl/cse_extract.sv
`timescale 1ns / 1ps
module cse_extract (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cse_pkg::t_issue  i_issue,
    output cse_pkg::t_result o_result
);

    localparam logic [cse_pkg::SIZE_W-1:0] FULL_SIZE = cse_pkg::SIZE_W'(cse_pkg::DATA_W);

    logic                        r_a_valid;
    logic [cse_pkg::SLOT_W-1:0]  r_a_slot;
    logic                        r_a_last;
    logic [cse_pkg::SIZE_W-1:0]  r_a_size;
    logic [cse_pkg::DATA_W-1:0]  r_a_shifted;

    logic [cse_pkg::SIZE_W-1:0]  n_a_size;
    logic [cse_pkg::SIZE_W-1:0]  n_b_shamt;
    logic [cse_pkg::DATA_W-1:0]  n_b_value;

    logic                        r_b_valid;
    logic [cse_pkg::SLOT_W-1:0]  r_b_slot;
    logic                        r_b_last;
    logic [cse_pkg::DATA_W-1:0]  r_b_value;

    // sizes above the payload width saturate
    always_comb begin
        if (i_issue.size > FULL_SIZE) begin
            n_a_size = FULL_SIZE;
        end else begin
            n_a_size = i_issue.size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_issue.valid;
        end
    end

    // field start moved to the top bit
    always_ff @(posedge i_clk) begin
        r_a_slot    <= i_issue.slot;
        r_a_last    <= i_issue.last;
        r_a_size    <= n_a_size;
        r_a_shifted <= i_issue.data << i_issue.start;
    end

    always_comb begin
        n_b_shamt = FULL_SIZE - r_a_size;
        if (r_a_size == '0) begin
            n_b_value = '0;
        end else begin
            n_b_value = r_a_shifted >> n_b_shamt[cse_pkg::START_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_slot  <= r_a_slot;
        r_b_last  <= r_a_last;
        r_b_value <= n_b_value;
    end

    assign o_result.valid = r_b_valid;
    assign o_result.slot  = r_b_slot;
    assign o_result.last  = r_b_last;
    assign o_result.value = r_b_value;

endmodule

>>> rtl/cse_checker.sv
`timescale 1ns / 1ps
`include "can_signal_extractor_core_assert.svh"
module cse_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_start,
    input logic                            o_busy,
    input logic                            o_strobe,
    input logic [cse_pkg::SLOT_W-1:0]      o_slot_index,
    input logic                            o_last_of_frame
);

    // a frame's results come in consecutive cycles with rising slot numbers
    `CSE_ASSERT_RUN(a_slot_order, i_clk, i_rst_n, o_strobe && !o_last_of_frame |=> o_strobe && (o_slot_index > $past(o_slot_index)), "slot order broken within an item")

    `CSE_ASSERT_RUN(a_last_with_strobe, i_clk, i_rst_n, o_last_of_frame |-> o_strobe, "last_of_frame without a result")

    // busy only follows an accepted item
    `CSE_ASSERT_RUN(a_busy_cause, i_clk, i_rst_n, !o_busy && !i_start |=> !o_busy, "busy rose without an accepted item")

    `CSE_ASSERT_ALL(a_reset_quiet, i_clk, !i_rst_n |=> !o_strobe && !o_busy, "outputs active after reset")

endmodule

bind can_signal_extractor_core cse_checker u_cse_checker (.*);

>>> bench/can_signal_extractor_core_tb.sv
`timescale 1ns / 1ps
module can_signal_extractor_core_tb;

    localparam int DRAIN_CYCLES  = 10;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_FRAMES  = 40;

    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} t_check;
    typedef enum logic {ROW_CFG, ROW_FRAME} t_row_kind;

    typedef struct {
        t_row_kind                          kind;
        logic [cse_pkg::CFG_IDX_W-1:0]      cfg_index;
        logic [cse_pkg::ENTRY_W-1:0]        cfg_value;
        logic [cse_pkg::FRAME_ID_W-1:0]     frame_id;
        logic [cse_pkg::DATA_W-1:0]         frame_data;
        t_check                             check;
        logic [cse_pkg::SLOT_W-1:0]         slot;
        logic [cse_pkg::DATA_W-1:0]         value;
    } t_row;

    typedef struct packed {
        logic [cse_pkg::SLOT_W-1:0]  slot;
        logic [cse_pkg::DATA_W-1:0]  value;
        logic                        last;
    } t_signal;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_start;
    logic                               o_busy;
    logic [cse_pkg::FRAME_ID_W-1:0]     i_frame_id;
    logic [cse_pkg::DATA_W-1:0]         i_frame_data;
    logic                               i_cfg_we;
    logic [cse_pkg::CFG_IDX_W-1:0]      i_cfg_index;
    logic [cse_pkg::ENTRY_W-1:0]        i_cfg_data;
    logic                               o_strobe;
    logic [cse_pkg::SLOT_W-1:0]         o_slot_index;
    logic [cse_pkg::DATA_W-1:0]         o_signal_value;
    logic                               o_last_of_frame;

    // how the item now on the inputs is to be checked
    t_check                             row_check;
    logic [cse_pkg::SLOT_W-1:0]         row_slot;
    logic [cse_pkg::DATA_W-1:0]         row_value;

    logic [cse_pkg::ENTRY_W-1:0]        descriptor_copy [cse_pkg::REG_SLOTS];
    t_signal                            expected_signals [$];
    t_signal                            wanted;
    t_row                               rows [$];
    int                                 mismatches;
    int                                 stall_cycles;

    can_signal_extractor_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_frame_id      (i_frame_id),
        .i_frame_data    (i_frame_data),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_strobe        (o_strobe),
        .o_slot_index    (o_slot_index),
        .o_signal_value  (o_signal_value),
        .o_last_of_frame (o_last_of_frame)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void queue_signal(t_signal s);
        expected_signals = {expected_signals, s};
    endfunction

    function automatic void add_row(t_row r);
        rows = {rows, r};
    endfunction

    function automatic logic [cse_pkg::ENTRY_W-1:0] descriptor(bit en, int size, int start,
                                                               logic [cse_pkg::ID_W-1:0] id);
        return {en, cse_pkg::SIZE_W'(size), cse_pkg::START_W'(start), id};
    endfunction

    function automatic logic [cse_pkg::DATA_W-1:0] pick_bits(
        logic [cse_pkg::DATA_W-1:0] data, int start, int size);
        int width;
        width = (size > cse_pkg::DATA_W) ? cse_pkg::DATA_W : size;
        if (width == 0) return '0;
        return (data << start) >> (cse_pkg::DATA_W - width);
    endfunction

    task automatic extract_signals(logic [cse_pkg::FRAME_ID_W-1:0] id,
                                   logic [cse_pkg::DATA_W-1:0] data);
        int last_slot;
        logic [cse_pkg::ENTRY_W-1:0] e;
        last_slot = -1;
        for (int k = 0; k < cse_pkg::SIGNAL_SLOTS; k++) begin
            e = descriptor_copy[k];
            if (e[cse_pkg::ENABLE_BIT] && e[cse_pkg::ID_W-1:0] == id[cse_pkg::ID_W-1:0])
                last_slot = k;
        end
        for (int k = 0; k < cse_pkg::SIGNAL_SLOTS; k++) begin
            e = descriptor_copy[k];
            if (e[cse_pkg::ENABLE_BIT] && e[cse_pkg::ID_W-1:0] == id[cse_pkg::ID_W-1:0]) begin
                queue_signal('{cse_pkg::SLOT_W'(k),
                    pick_bits(data, int'(e[cse_pkg::START_LSB +: cse_pkg::START_W]),
                              int'(e[cse_pkg::SIZE_LSB +: cse_pkg::SIZE_W])),
                    k == last_slot});
            end
        end
    endtask

    function automatic t_row cfg_row(int idx, logic [cse_pkg::ENTRY_W-1:0] value);
        t_row r;
        r.kind = ROW_CFG;
        r.cfg_index = cse_pkg::CFG_IDX_W'(idx);
        r.cfg_value = value;
        r.frame_id = '0;
        r.frame_data = '0;
        r.check = CHK_NONE;
        r.slot = '0;
        r.value = '0;
        return r;
    endfunction

    function automatic t_row frame_row(logic [cse_pkg::FRAME_ID_W-1:0] id,
                                       logic [cse_pkg::DATA_W-1:0] data,
                                       t_check chk, int slot,
                                       logic [cse_pkg::DATA_W-1:0] value);
        t_row r;
        r.kind = ROW_FRAME;
        r.cfg_index = '0;
        r.cfg_value = '0;
        r.frame_id = id;
        r.frame_data = data;
        r.check = chk;
        r.slot = cse_pkg::SLOT_W'(slot);
        r.value = value;
        return r;
    endfunction

    function automatic logic [cse_pkg::ENTRY_W-1:0] random_descriptor(bit all_on,
                                                      logic [cse_pkg::ID_W-1:0] id);
        bit en;
        int size;
        en = all_on || ($urandom_range(0, 9) < 8);
        case ($urandom_range(0, 5))
            0: size = 0;
            1: size = 1;
            2: size = 64;
            3: size = $urandom_range(65, 127);
            default: size = $urandom_range(2, 63);
        endcase
        return descriptor(en, size, $urandom_range(0, 63), id);
    endfunction

    // descriptor mirror and expected results, taken at the accepting edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < cse_pkg::REG_SLOTS; k++) descriptor_copy[k] = '0;
        end else begin
            if (i_cfg_we) descriptor_copy[i_cfg_index] = i_cfg_data;
            if (i_start && !o_busy) begin
                case (row_check)
                    CHK_MODEL: extract_signals(i_frame_id, i_frame_data);
                    CHK_ONE: queue_signal('{row_slot, row_value, 1'b1});
                    default: ;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (expected_signals.size() == 0) begin
                $display("%0t: unexpected item slot %0d value %h last %0b", $time,
                         o_slot_index, o_signal_value, o_last_of_frame);
                mismatches++;
            end else begin
                wanted = expected_signals.pop_front();
                if (o_slot_index !== wanted.slot) begin
                    $display("%0t: slot_index expected %0d got %0d", $time,
                             wanted.slot, o_slot_index);
                    mismatches++;
                end
                if (o_signal_value !== wanted.value) begin
                    $display("%0t: signal_value expected %h got %h", $time,
                             wanted.value, o_signal_value);
                    mismatches++;
                end
                if (o_last_of_frame !== wanted.last) begin
                    $display("%0t: last_of_frame expected %0b got %0b", $time,
                             wanted.last, o_last_of_frame);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_strobe || i_cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_frame(logic [cse_pkg::FRAME_ID_W-1:0] id,
                              logic [cse_pkg::DATA_W-1:0] data,
                              t_check chk, logic [cse_pkg::SLOT_W-1:0] slot,
                              logic [cse_pkg::DATA_W-1:0] value);
        i_start <= 1'b1;
        i_frame_id <= id;
        i_frame_data <= data;
        row_check <= chk;
        row_slot <= slot;
        row_value <= value;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic pause(bit allowed);
        if (allowed && $urandom_range(0, 99) < 8) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (expected_signals.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_descriptor(logic [cse_pkg::CFG_IDX_W-1:0] idx,
                                    logic [cse_pkg::ENTRY_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    task automatic build_rows();
        // reset state: every slot disabled
        add_row(frame_row(29'h0, 64'h0, CHK_NONE, 0, '0));
        add_row(frame_row(29'h1FFF_FFFF, '1, CHK_NONE, 0, '0));
        add_row(cfg_row(0, descriptor(1, 64, 0, 16'h0123)));
        add_row(cfg_row(1, descriptor(1, 1, 0, 16'h0456)));
        add_row(cfg_row(2, descriptor(1, 1, 63, 16'h0789)));
        add_row(cfg_row(3, descriptor(1, 8, 60, 16'h0ABC)));
        add_row(cfg_row(4, descriptor(1, 127, 8, 16'h0DEF)));
        add_row(cfg_row(5, descriptor(1, 0, 5, 16'hFFFF)));
        add_row(cfg_row(6, descriptor(1, 16, 16, 16'h1111)));
        add_row(cfg_row(7, descriptor(1, 8, 32, 16'h1111)));
        add_row(frame_row(29'h0123, '1, CHK_ONE, 0, '1));
        add_row(frame_row(29'h0123, 64'h0, CHK_ONE, 0, 64'h0));
        add_row(frame_row(29'h1FFF_0123, 64'h0123_4567_89AB_CDEF, CHK_ONE, 0,
                          64'h0123_4567_89AB_CDEF));
        add_row(frame_row(29'h0456, 64'h8000_0000_0000_0000, CHK_ONE, 1, 64'h1));
        add_row(frame_row(29'h0456, 64'h7FFF_FFFF_FFFF_FFFF, CHK_ONE, 1, 64'h0));
        add_row(frame_row(29'h0789, 64'h1, CHK_ONE, 2, 64'h1));
        add_row(frame_row(29'h0789, 64'hFFFF_FFFF_FFFF_FFFE, CHK_ONE, 2, 64'h0));
        // field running past the payload
        add_row(frame_row(29'h0ABC, '1, CHK_ONE, 3, 64'hF0));
        // oversize field saturates
        add_row(frame_row(29'h0DEF, 64'h0123_4567_89AB_CDEF, CHK_ONE, 4,
                          64'h2345_6789_ABCD_EF00));
        add_row(frame_row(29'h0FFFF, '1, CHK_ONE, 5, 64'h0));
        add_row(frame_row(29'h1FFF_FFFF, 64'hA5A5_5A5A_C3C3_3C3C, CHK_ONE, 5, 64'h0));
        // two slots sharing an id
        add_row(frame_row(29'h1111, 64'h0123_4567_89AB_CDEF, CHK_MODEL, 0, '0));
        add_row(frame_row(29'h2222, '1, CHK_NONE, 0, '0));
        add_row(frame_row(29'h0000, '1, CHK_NONE, 0, '0));
        add_row(cfg_row(0, 30'h0));
        add_row(cfg_row(1, descriptor(1, 64, 0, 16'h5A5A)));
        add_row(cfg_row(2, descriptor(1, 12, 52, 16'h5A5A)));
        add_row(cfg_row(3, descriptor(0, 8, 0, 16'h5A5A)));
        add_row(cfg_row(4, descriptor(1, 0, 0, 16'h5A5A)));
        add_row(cfg_row(5, descriptor(1, 100, 40, 16'h5A5A)));
        add_row(cfg_row(6, descriptor(1, 32, 48, 16'h5A5A)));
        add_row(cfg_row(7, 30'h3FFF_FFFF));
        add_row(frame_row(29'h5A5A, 64'hDEAD_BEEF_0F1E_2D3C, CHK_MODEL, 0, '0));
        add_row(frame_row(29'h0000, '1, CHK_NONE, 0, '0));
        add_row(frame_row(29'hFFFF, 64'h1, CHK_ONE, 7, 64'h8000_0000_0000_0000));
        add_row(frame_row(29'hFFFF, 64'hFFFF_FFFF_FFFF_FFFE, CHK_ONE, 7, 64'h0));
    endtask

    initial begin
        int n_pool;
        int sent;
        bit cfg_open;
        logic [cse_pkg::ID_W-1:0] id_pool [4];
        logic [cse_pkg::FRAME_ID_W-1:0] id;
        logic [cse_pkg::DATA_W-1:0] data;

        mismatches = 0;
        stall_cycles = 0;
        sent = 0;
        cfg_open = 1'b0;
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_frame_id <= '0;
        i_frame_data <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        row_check <= CHK_MODEL;
        row_slot <= '0;
        row_value <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        build_rows();
        foreach (rows[r]) begin
            if (rows[r].kind == ROW_CFG) begin
                if (!cfg_open) drain();
                write_descriptor(rows[r].cfg_index, rows[r].cfg_value);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open) i_cfg_we <= 1'b0;
                cfg_open = 1'b0;
                send_frame(rows[r].frame_id, rows[r].frame_data, rows[r].check,
                           rows[r].slot, rows[r].value);
                pause(1'b1);
            end
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain();
            // first phase: one shared id on all slots, frames that carry that id fill the serialiser
            n_pool = (p == 0) ? 1 : $urandom_range(1, 4);
            for (int j = 0; j < 4; j++) id_pool[j] = cse_pkg::ID_W'($urandom);
            if (p == RANDOM_PHASES - 1) begin
                id_pool[0] = '1;
                id_pool[1] = '0;
                n_pool = 3;
            end
            for (int k = 0; k < cse_pkg::REG_SLOTS; k++) begin
                write_descriptor(cse_pkg::CFG_IDX_W'(k),
                                 random_descriptor(p == 0,
                                                   id_pool[$urandom_range(0, n_pool - 1)]));
            end
            i_cfg_we <= 1'b0;
            for (int j = 0; j < PHASE_FRAMES; j++) begin
                id = cse_pkg::FRAME_ID_W'($urandom);
                if ($urandom_range(0, 99) < 80) begin
                    id = {id[cse_pkg::FRAME_ID_W-1:cse_pkg::ID_W],
                          id_pool[$urandom_range(0, n_pool - 1)]};
                end
                case ($urandom_range(0, 19))
                    0: data = '1;
                    1: data = '0;
                    default: data = {$urandom, $urandom};
                endcase
                send_frame(id, data, CHK_MODEL, '0, '0);
                sent++;
                // long stretch with the sender never idle
                pause(sent < 60 || sent >= 120);
            end
        end

        drain();
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/cse_pkg.sv
rtl/cse_extract.sv
rtl/can_signal_extractor_core.sv
rtl/cse_checker.sv
bench/can_signal_extractor_core_tb.sv
